>>> design/bsss_pkg.sv
// Shared types and constants for the burst spacing sample sequencer.
// Holds command codes, register indexes, reset values and the state and action enums.
// No dependencies.
package bsss_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int TIME_BITS_DEF   = 20;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 4;
  localparam int IN_TIME_W  = 20;
  localparam int REPS_W     = 16;
  localparam int WORD_W     = 24;
  localparam int COUNT_IN_W = 5;
  localparam int TICK_W     = 16;
  localparam int SAMPLE_W   = 32;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0]        SYNC_BYTE         = 8'h5A;
  localparam logic [TICK_W-1:0] TICK_TIME_RST     = 16'd80;
  localparam logic [WORD_W-1:0] DEFAULT_WORD_RST  = 24'd75726;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_COMMIT = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_TICK_TIME    = 1'b0,
    REG_DEFAULT_WORD = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // What a tick does once the table entry it needs has been read.
  typedef enum logic [1:0] {
    ACT_DEFAULT,
    ACT_COUNT,
    ACT_SPACE,
    ACT_BURST
  } act_t;

endpackage

>>> design/burst_spacing_sample_sequencer.sv
// Burst spacing sample sequencer: one clock-divider sample word per tick transfer.
// A tick is accepted and its table entry is read into a register at that edge; the result
// is registered in the apply state once the output is not stalled.
// Write and commit transfers give no result.
// in_stall is high while a tick is applied; no new transfer is taken before its result.
// Reset (rst_n low, synchronous) clears control state and loads the register defaults.
module burst_spacing_sample_sequencer #(
  parameter int MAX_ENTRIES = bsss_pkg::MAX_ENTRIES_DEF,
  parameter int TIME_BITS   = bsss_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsss_pkg::CMD_W-1:0]          in_command,
  input  logic [bsss_pkg::IDX_W-1:0]          in_entry_index,
  input  logic [bsss_pkg::IN_TIME_W-1:0]      in_burst_time,
  input  logic [bsss_pkg::IN_TIME_W-1:0]      in_spacing_time,
  input  logic [bsss_pkg::REPS_W-1:0]         in_repeat_total,
  input  logic [bsss_pkg::WORD_W-1:0]         in_burst_word,
  input  logic [bsss_pkg::WORD_W-1:0]         in_idle_word,
  input  logic [bsss_pkg::COUNT_IN_W-1:0]     in_entry_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bsss_pkg::SAMPLE_W-1:0]       out_sample_word,
  output logic                                out_phase,
  output logic                                out_list_wrapped,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bsss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bsss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = PTR_W + 1;
  localparam int DEPTH = 2 ** ADDR_W;
  localparam int TL_W = TIME_BITS + 2;
  localparam int DW = ((TL_W > bsss_pkg::TICK_W + 1) ? TL_W : bsss_pkg::TICK_W + 1) + 1;
  localparam logic signed [DW-1:0] T_FLOOR =
    {{(DW - TIME_BITS - 1){1'b1}}, {(TIME_BITS + 1){1'b0}}};

  typedef struct packed {
    logic [TIME_BITS-1:0]            burst;
    logic [TIME_BITS-1:0]            spacing;
    logic [bsss_pkg::REPS_W-1:0]     reps;
    logic [bsss_pkg::WORD_W-1:0]     bword;
    logic [bsss_pkg::WORD_W-1:0]     iword;
  } entry_t;

  typedef struct packed {
    bsss_pkg::act_t                  act;
    logic signed [TL_W-1:0]          t;
    logic [PTR_W-1:0]                ptr;
    logic                            swap;
    logic                            wrapped;
    logic                            reload;
    logic [bsss_pkg::REPS_W-1:0]     reps;
  } plan_t;

  // Registers
  bsss_pkg::state_t               state_r, state_nxt;
  logic [bsss_pkg::TICK_W-1:0]    tick_time_r, tick_time_nxt;
  logic [bsss_pkg::WORD_W-1:0]    default_word_r, default_word_nxt;
  logic                           active_bank_r, active_bank_nxt;
  logic [CNT_W-1:0]               active_count_r, active_count_nxt;
  logic [CNT_W-1:0]               pending_count_r, pending_count_nxt;
  logic                           pending_valid_r, pending_valid_nxt;
  logic [PTR_W-1:0]               entry_ptr_r, entry_ptr_nxt;
  logic                           phase_flag_r, phase_flag_nxt;
  logic signed [TL_W-1:0]         time_left_r, time_left_nxt;
  logic [bsss_pkg::REPS_W-1:0]    repeats_left_r, repeats_left_nxt;
  logic [bsss_pkg::WORD_W-1:0]    current_word_r, current_word_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [bsss_pkg::WORD_W-1:0]    out_word_r;
  logic                           out_phase_r;
  logic                           out_wrapped_r;
  plan_t                          plan_r;
  entry_t                         rd_data_r;

  entry_t                         table_mem [DEPTH];

  // Combinational
  logic                           in_fire;
  logic                           tick_fire;
  logic                           wr_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              rd_addr;
  entry_t                         wr_data;
  plan_t                          plan;
  logic signed [DW-1:0]           diff;
  logic signed [DW-1:0]           t_sat;
  logic                           t_le0;
  logic [bsss_pkg::REPS_W-1:0]    reps_dec;
  logic [CNT_W:0]                 next_ptr_w;
  logic                           apply_fire;
  logic                           cfg_wr;
  logic [bsss_pkg::REPS_W-1:0]    reps_load;
  logic [bsss_pkg::WORD_W-1:0]    res_word;
  logic                           res_phase;

  assign pready    = 1'b1;
  assign in_stall  = (state_r != bsss_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign tick_fire = in_fire && (in_command == bsss_pkg::CMD_TICK);
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_comb begin
    unique case (bsss_pkg::reg_idx_t'(paddr[2]))
      bsss_pkg::REG_TICK_TIME:
        prdata = bsss_pkg::APB_DATA_W'(tick_time_r);
      bsss_pkg::REG_DEFAULT_WORD:
        prdata = bsss_pkg::APB_DATA_W'(default_word_r);
      default:
        prdata = '0;
    endcase
  end

  // Table writes always land in the bank that is not active.
  assign wr_en   = in_fire && (in_command == bsss_pkg::CMD_WRITE) &&
                   (32'(in_entry_index) < 32'(MAX_ENTRIES));
  assign wr_addr = {~active_bank_r, PTR_W'(in_entry_index)};
  assign wr_data = '{burst:   TIME_BITS'(in_burst_time),
                     spacing: TIME_BITS'(in_spacing_time),
                     reps:    in_repeat_total,
                     bword:   in_burst_word,
                     iword:   in_idle_word};

  // Decide at acceptance which entry the tick needs, from the state alone.
  assign diff   = DW'(time_left_r) - $signed(DW'(tick_time_r));
  assign t_sat  = (diff < T_FLOOR) ? T_FLOOR : diff;
  assign t_le0  = t_sat[DW-1] || (t_sat == '0);
  assign reps_dec   = (repeats_left_r > 16'd1) ? repeats_left_r - 16'd1 : '0;
  assign next_ptr_w = (CNT_W + 1)'(entry_ptr_r) + (CNT_W + 1)'(1);

  always_comb begin
    plan.act     = bsss_pkg::ACT_DEFAULT;
    plan.t       = TL_W'(t_sat);
    plan.ptr     = entry_ptr_r;
    plan.swap    = 1'b0;
    plan.wrapped = 1'b0;
    plan.reload  = 1'b0;
    plan.reps    = repeats_left_r;
    if (active_count_r == '0) begin
      // The first committed list starts at entry 0 in its burst phase.
      if (pending_valid_r) begin
        plan.act     = bsss_pkg::ACT_BURST;
        plan.t       = '0;
        plan.ptr     = '0;
        plan.swap    = 1'b1;
        plan.wrapped = 1'b1;
        plan.reload  = 1'b1;
      end
    end else if (t_le0) begin
      if (!phase_flag_r) begin
        plan.act = bsss_pkg::ACT_SPACE;
      end else begin
        plan.act  = bsss_pkg::ACT_BURST;
        plan.reps = reps_dec;
        if (reps_dec == '0) begin
          plan.reload = 1'b1;
          if (next_ptr_w >= (CNT_W + 1)'(active_count_r)) begin
            plan.ptr     = '0;
            plan.wrapped = 1'b1;
            plan.swap    = pending_valid_r;
          end else begin
            plan.ptr = PTR_W'(next_ptr_w);
          end
        end
      end
    end else begin
      plan.act = bsss_pkg::ACT_COUNT;
    end
  end

  assign rd_addr = {(plan.swap ? ~active_bank_r : active_bank_r), plan.ptr};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (tick_fire) begin
      rd_data_r <= table_mem[rd_addr];
      plan_r    <= plan;
    end
  end

  assign apply_fire = (state_r == bsss_pkg::ST_APPLY) && (!out_valid_r || !out_stall);
  assign reps_load  = (rd_data_r.reps == '0) ? 16'd1 : rd_data_r.reps;

  always_comb begin
    unique case (plan_r.act)
      bsss_pkg::ACT_DEFAULT: begin
        res_word  = default_word_r;
        res_phase = phase_flag_r;
      end
      bsss_pkg::ACT_COUNT: begin
        res_word  = current_word_r;
        res_phase = phase_flag_r;
      end
      bsss_pkg::ACT_SPACE: begin
        res_word  = rd_data_r.iword;
        res_phase = 1'b1;
      end
      bsss_pkg::ACT_BURST: begin
        res_word  = rd_data_r.bword;
        res_phase = 1'b0;
      end
      default: begin
        res_word  = current_word_r;
        res_phase = phase_flag_r;
      end
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    tick_time_nxt     = tick_time_r;
    default_word_nxt  = default_word_r;
    active_bank_nxt   = active_bank_r;
    active_count_nxt  = active_count_r;
    pending_count_nxt = pending_count_r;
    pending_valid_nxt = pending_valid_r;
    entry_ptr_nxt     = entry_ptr_r;
    phase_flag_nxt    = phase_flag_r;
    time_left_nxt     = time_left_r;
    repeats_left_nxt  = repeats_left_r;
    current_word_nxt  = current_word_r;
    out_valid_nxt     = out_valid_r && out_stall;

    if (cfg_wr) begin
      unique case (bsss_pkg::reg_idx_t'(paddr[2]))
        bsss_pkg::REG_TICK_TIME:    tick_time_nxt    = pwdata[bsss_pkg::TICK_W-1:0];
        bsss_pkg::REG_DEFAULT_WORD: default_word_nxt = pwdata[bsss_pkg::WORD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      bsss_pkg::ST_IDLE: begin
        if (in_fire && (in_command == bsss_pkg::CMD_COMMIT) && (in_entry_count != '0)) begin
          pending_valid_nxt = 1'b1;
          pending_count_nxt = (32'(in_entry_count) > 32'(MAX_ENTRIES)) ?
                              CNT_W'(MAX_ENTRIES) : CNT_W'(in_entry_count);
        end
        if (tick_fire) begin
          state_nxt = bsss_pkg::ST_APPLY;
        end
      end
      bsss_pkg::ST_APPLY: begin
        if (apply_fire) begin
          state_nxt     = bsss_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          unique case (plan_r.act)
            bsss_pkg::ACT_DEFAULT: ;
            bsss_pkg::ACT_COUNT: begin
              time_left_nxt = plan_r.t;
            end
            bsss_pkg::ACT_SPACE: begin
              time_left_nxt    = plan_r.t + $signed({2'b00, rd_data_r.spacing});
              phase_flag_nxt   = 1'b1;
              current_word_nxt = rd_data_r.iword;
            end
            bsss_pkg::ACT_BURST: begin
              time_left_nxt    = plan_r.t + $signed({2'b00, rd_data_r.burst});
              phase_flag_nxt   = 1'b0;
              current_word_nxt = rd_data_r.bword;
              if (plan_r.reload) begin
                entry_ptr_nxt    = plan_r.ptr;
                repeats_left_nxt = reps_load;
              end else begin
                repeats_left_nxt = plan_r.reps;
              end
              if (plan_r.swap) begin
                active_bank_nxt   = ~active_bank_r;
                active_count_nxt  = pending_count_r;
                pending_valid_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = bsss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= bsss_pkg::ST_IDLE;
      tick_time_r     <= bsss_pkg::TICK_TIME_RST;
      default_word_r  <= bsss_pkg::DEFAULT_WORD_RST;
      active_bank_r   <= 1'b0;
      active_count_r  <= '0;
      pending_count_r <= '0;
      pending_valid_r <= 1'b0;
      entry_ptr_r     <= '0;
      phase_flag_r    <= 1'b0;
      time_left_r     <= '0;
      repeats_left_r  <= '0;
      current_word_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      tick_time_r     <= tick_time_nxt;
      default_word_r  <= default_word_nxt;
      active_bank_r   <= active_bank_nxt;
      active_count_r  <= active_count_nxt;
      pending_count_r <= pending_count_nxt;
      pending_valid_r <= pending_valid_nxt;
      entry_ptr_r     <= entry_ptr_nxt;
      phase_flag_r    <= phase_flag_nxt;
      time_left_r     <= time_left_nxt;
      repeats_left_r  <= repeats_left_nxt;
      current_word_r  <= current_word_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload holds while the output transfer is stalled.
  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_word_r    <= res_word;
      out_phase_r   <= res_phase;
      out_wrapped_r <= plan_r.wrapped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_word  = {bsss_pkg::SYNC_BYTE, out_word_r};
  assign out_phase        = out_phase_r;
  assign out_list_wrapped = out_wrapped_r;

  a_result_from_apply : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bsss_pkg::ST_APPLY))
    else $error("result appeared without a tick being applied");

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(active_count_r) <= 32'(MAX_ENTRIES)) && (32'(pending_count_r) <= 32'(MAX_ENTRIES)))
    else $error("list count above table size");

  a_ptr_in_list : assert property (@(posedge clk) disable iff (!rst_n)
    (active_count_r != '0) |-> ((CNT_W + 1)'(entry_ptr_r) < (CNT_W + 1)'(active_count_r)))
    else $error("entry pointer outside the active list");

  a_list_stays : assert property (@(posedge clk) disable iff (!rst_n)
    (active_count_r != '0) |=> (active_count_r != '0))
    else $error("active list was dropped");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the burst spacing sample sequencer.
// A behavioral predictor checks every result transfer. Random bursts, receiver stalls and
// register writes are applied. Depends on bsss_pkg and burst_spacing_sample_sequencer.
module testbench;
  import bsss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int     TL_W       = TIME_BITS_DEF + 2;
  localparam longint TIME_FLOOR = -(longint'(1) << (TIME_BITS_DEF + 1));

  typedef struct packed {
    logic [IN_TIME_W-1:0] burst;
    logic [IN_TIME_W-1:0] spacing;
    logic [REPS_W-1:0]    reps;
    logic [WORD_W-1:0]    bword;
    logic [WORD_W-1:0]    iword;
  } seq_entry_t;

  typedef struct {
    seq_entry_t               tbl [2*MAX_ENTRIES_DEF];
    logic [TICK_W-1:0]        tick_time;
    logic [WORD_W-1:0]        default_word;
    logic                     active_bank;
    logic [4:0]               active_count;
    logic [4:0]               pending_count;
    logic                     pending_valid;
    logic [4:0]               entry_pointer;
    logic                     phase_flag;
    logic signed [TL_W-1:0]   time_left;
    logic [REPS_W-1:0]        repeats_left;
    logic [WORD_W-1:0]        current_word;
  } seq_model_t;

  typedef struct packed {
    logic [CMD_W-1:0]      command;
    logic [IDX_W-1:0]      entry_index;
    logic [IN_TIME_W-1:0]  burst_time;
    logic [IN_TIME_W-1:0]  spacing_time;
    logic [REPS_W-1:0]     repeat_total;
    logic [WORD_W-1:0]     burst_word;
    logic [WORD_W-1:0]     idle_word;
    logic [COUNT_IN_W-1:0] entry_count;
  } seq_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_word;
    logic                phase;
    logic                list_wrapped;
  } sample_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [IDX_W-1:0]      in_entry_index = '0;
  logic [IN_TIME_W-1:0]  in_burst_time = '0;
  logic [IN_TIME_W-1:0]  in_spacing_time = '0;
  logic [REPS_W-1:0]     in_repeat_total = '0;
  logic [WORD_W-1:0]     in_burst_word = '0;
  logic [WORD_W-1:0]     in_idle_word = '0;
  logic [COUNT_IN_W-1:0] in_entry_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample_word;
  logic                  out_phase;
  logic                  out_list_wrapped;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  seq_model_t  model_now;   // advanced as items are accepted
  seq_model_t  model_plan;  // advanced as items are generated
  bit          entry_loaded [2*MAX_ENTRIES_DEF];
  seq_item_t   item_queue [$];
  sample_t     expected_samples [$];
  int          fail_count = 0;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        stall_next = 1'b0;

  burst_spacing_sample_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_burst_time    (in_burst_time),
    .in_spacing_time  (in_spacing_time),
    .in_repeat_total  (in_repeat_total),
    .in_burst_word    (in_burst_word),
    .in_idle_word     (in_idle_word),
    .in_entry_count   (in_entry_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_word  (out_sample_word),
    .out_phase        (out_phase),
    .out_list_wrapped (out_list_wrapped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  function automatic void model_reset(output seq_model_t s);
    foreach (s.tbl[i]) s.tbl[i] = '0;
    s.tick_time     = TICK_TIME_RST;
    s.default_word  = DEFAULT_WORD_RST;
    s.active_bank   = 1'b0;
    s.active_count  = '0;
    s.pending_count = '0;
    s.pending_valid = 1'b0;
    s.entry_pointer = '0;
    s.phase_flag    = 1'b0;
    s.time_left     = '0;
    s.repeats_left  = '0;
    s.current_word  = '0;
  endfunction

  function automatic void config_apply(inout seq_model_t s, input reg_idx_t which,
                                       input logic [APB_DATA_W-1:0] value);
    case (which)
      REG_TICK_TIME:    s.tick_time = value[TICK_W-1:0];
      REG_DEFAULT_WORD: s.default_word = value[WORD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic seq_entry_t entry_at(input seq_model_t s);
    logic [IDX_W-1:0] p;
    p = (s.entry_pointer < 5'(MAX_ENTRIES_DEF)) ? s.entry_pointer[IDX_W-1:0] : '0;
    return s.tbl[{s.active_bank, p}];
  endfunction

  function automatic logic [REPS_W-1:0] reps_of(input seq_entry_t e);
    return (e.reps == '0) ? REPS_W'(1) : e.reps;
  endfunction

  // Advances the sequencer by one item; returns 1 when the item yields a sample.
  function automatic bit sequence_step(inout seq_model_t s, input seq_item_t it,
                                       output sample_t r);
    seq_entry_t       e;
    longint           t;
    logic [WORD_W-1:0] word;
    logic             wrapped;
    r = '0;
    wrapped = 1'b0;
    case (it.command)
      CMD_WRITE: begin
        s.tbl[{~s.active_bank, it.entry_index}] = '{it.burst_time, it.spacing_time,
                                                    it.repeat_total, it.burst_word,
                                                    it.idle_word};
        return 1'b0;
      end
      CMD_COMMIT: begin
        if (it.entry_count != '0) begin
          s.pending_count = (it.entry_count > 5'(MAX_ENTRIES_DEF)) ? 5'(MAX_ENTRIES_DEF)
                                                                    : it.entry_count;
          s.pending_valid = 1'b1;
        end
        return 1'b0;
      end
      CMD_TICK: begin
        if (s.active_count == '0) begin
          if (s.pending_valid) begin
            s.active_bank   = ~s.active_bank;
            s.active_count  = s.pending_count;
            s.pending_valid = 1'b0;
            s.entry_pointer = '0;
            e = entry_at(s);
            s.repeats_left  = reps_of(e);
            s.time_left     = TL_W'(e.burst);
            s.phase_flag    = 1'b0;
            s.current_word  = e.bword;
            wrapped = 1'b1;
            word = s.current_word;
          end else begin
            word = s.default_word;
          end
        end else begin
          t = longint'(s.time_left) - longint'(s.tick_time);
          if (t < TIME_FLOOR) t = TIME_FLOOR;
          if (t <= 0) begin
            e = entry_at(s);
            if (s.phase_flag == 1'b0) begin
              s.time_left    = TL_W'(t + longint'(e.spacing));
              s.phase_flag   = 1'b1;
              s.current_word = e.iword;
            end else begin
              s.repeats_left = (s.repeats_left > 1) ? s.repeats_left - 1'b1 : '0;
              if (s.repeats_left == '0) begin
                s.entry_pointer = s.entry_pointer + 1'b1;
                if (s.entry_pointer >= s.active_count) begin
                  if (s.pending_valid) begin
                    s.active_bank   = ~s.active_bank;
                    s.active_count  = s.pending_count;
                    s.pending_valid = 1'b0;
                  end
                  s.entry_pointer = '0;
                  wrapped = 1'b1;
                end
                e = entry_at(s);
                s.repeats_left = reps_of(e);
              end
              s.time_left    = TL_W'(t + longint'(e.burst));
              s.phase_flag   = 1'b0;
              s.current_word = e.bword;
            end
          end else begin
            s.time_left = TL_W'(t);
          end
          word = s.current_word;
        end
        r.sample_word  = {SYNC_BYTE, word};
        r.phase        = s.phase_flag;
        r.list_wrapped = wrapped;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Stimulus generation -------------------------------------------------------

  function automatic seq_item_t blank_item(input logic [CMD_W-1:0] cmd);
    seq_item_t it;
    it.command      = cmd;
    it.entry_index  = IDX_W'($urandom);
    it.burst_time   = IN_TIME_W'($urandom);
    it.spacing_time = IN_TIME_W'($urandom);
    it.repeat_total = REPS_W'($urandom);
    it.burst_word   = WORD_W'($urandom);
    it.idle_word    = WORD_W'($urandom);
    it.entry_count  = COUNT_IN_W'($urandom);
    return it;
  endfunction

  function automatic seq_item_t entry_item(input logic [IDX_W-1:0] idx,
                                           input logic [IN_TIME_W-1:0] b,
                                           input logic [IN_TIME_W-1:0] sp,
                                           input logic [REPS_W-1:0] reps,
                                           input logic [WORD_W-1:0] bw,
                                           input logic [WORD_W-1:0] iw);
    seq_item_t it;
    it = blank_item(CMD_WRITE);
    it.entry_index  = idx;
    it.burst_time   = b;
    it.spacing_time = sp;
    it.repeat_total = reps;
    it.burst_word   = bw;
    it.idle_word    = iw;
    return it;
  endfunction

  // Durations mostly stay near the tick so that phases, entries and lists turn over often.
  function automatic logic [IN_TIME_W-1:0] pick_duration();
    int tk;
    tk = int'(model_plan.tick_time);
    if (tk >= 16384 && $urandom_range(0, 3) == 0) return IN_TIME_W'($urandom);
    return IN_TIME_W'($urandom_range(0, 3 * tk + 8));
  endfunction

  function automatic void fill_entry(inout seq_item_t it);
    int r;
    r = $urandom_range(0, 99);
    it.burst_time   = pick_duration();
    it.spacing_time = pick_duration();
    if (r < 70)      it.repeat_total = REPS_W'($urandom_range(0, 2));
    else if (r < 95) it.repeat_total = REPS_W'($urandom_range(3, 12));
    else             it.repeat_total = REPS_W'($urandom_range(13, 40));
  endfunction

  function automatic int loaded_prefix();
    int k;
    k = 0;
    while (k < MAX_ENTRIES_DEF && entry_loaded[{~model_plan.active_bank, IDX_W'(k)}]) k++;
    return k;
  endfunction

  function automatic void plan_item(input seq_item_t it);
    sample_t discard;
    if (it.command == CMD_WRITE)
      entry_loaded[{~model_plan.active_bank, it.entry_index}] = 1'b1;
    void'(sequence_step(model_plan, it, discard));
    item_queue.push_back(it);
  endfunction

  // Mostly complete lists (writes, commit, ticks); the rest is loose traffic.
  task automatic add_random(input int target);
    int        added;
    int        pick;
    int        n;
    int        ticks;
    int        prefix;
    seq_item_t it;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        n = (pick < 65) ? $urandom_range(1, 3) : (pick < 90) ? $urandom_range(4, 15)
                                                             : MAX_ENTRIES_DEF;
        for (int i = 0; i < n; i++) begin
          it = blank_item(CMD_WRITE);
          it.entry_index = IDX_W'(i);
          fill_entry(it);
          plan_item(it);
        end
        it = blank_item(CMD_COMMIT);
        it.entry_count = (n == MAX_ENTRIES_DEF) ? COUNT_IN_W'($urandom_range(16, 31))
                                                : COUNT_IN_W'(n);
        plan_item(it);
        ticks = $urandom_range(10, 80);
        repeat (ticks) plan_item(blank_item(CMD_TICK));
        added += n + 1 + ticks;
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          plan_item(blank_item(CMD_UNUSED));
        end else begin
          it = blank_item(CMD_COMMIT);
          it.entry_count = '0;
          plan_item(it);
        end
      end else if (pick < 88) begin
        it = blank_item(CMD_WRITE);
        // An entry with raw full-range fields is always overwritten before it can be read.
        if ($urandom_range(0, 2) == 0) begin
          plan_item(it);
          added++;
        end
        fill_entry(it);
        plan_item(it);
        added++;
      end else if (pick < 93) begin
        prefix = loaded_prefix();
        if (prefix > 0) begin
          it = blank_item(CMD_COMMIT);
          it.entry_count = (prefix == MAX_ENTRIES_DEF)
                           ? COUNT_IN_W'($urandom_range(1, 31))
                           : COUNT_IN_W'($urandom_range(1, prefix));
          plan_item(it);
          added++;
        end
      end else begin
        ticks = $urandom_range(1, 10);
        repeat (ticks) plan_item(blank_item(CMD_TICK));
        added += ticks;
      end
    end
  endtask

  // Waits until all items are taken and all samples are back, then lets the block settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (item_queue.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t which, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    config_apply(model_now, which, value);
    config_apply(model_plan, which, value);
  endtask

  // Clock, reset and test sequence --------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : stimulus
    seq_item_t it;
    model_reset(model_now);
    model_reset(model_plan);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // With no list committed, ticks give the default word and other commands give nothing.
    plan_item(blank_item(CMD_TICK));
    plan_item(blank_item(CMD_UNUSED));
    it = blank_item(CMD_COMMIT);
    it.entry_count = '0;
    plan_item(it);
    plan_item(blank_item(CMD_TICK));
    wait_idle();
    cfg_write(REG_DEFAULT_WORD, 32'h00FF_FFFF);
    plan_item(blank_item(CMD_TICK));
    wait_idle();
    cfg_write(REG_DEFAULT_WORD, 32'h0);

    // First list: zero-length phases, a spacing shorter than the tick, and a wrap.
    plan_item(entry_item(4'd15, '1, '1, '1, '1, '1));
    plan_item(entry_item(4'd15, '0, '0, '0, '0, '0));
    plan_item(entry_item(4'd0, '0, '0, '0, '0, 24'hFF_FFFF));
    plan_item(entry_item(4'd1, 20'd100, 20'd30, 16'd2, 24'h12_3456, 24'hAB_CDEF));
    it = blank_item(CMD_COMMIT);
    it.entry_count = 5'd2;
    plan_item(it);
    repeat (10) plan_item(blank_item(CMD_TICK));
    add_random(120);

    wait_idle();
    cfg_write(REG_TICK_TIME, 32'd1);
    cfg_write(REG_DEFAULT_WORD, {8'h00, WORD_W'($urandom)});
    add_random(120);

    // The largest tick drives the remaining time down to its floor.
    wait_idle();
    cfg_write(REG_TICK_TIME, 32'd65535);
    add_random(120);

    // A zero tick lets no time pass at all.
    wait_idle();
    cfg_write(REG_TICK_TIME, 32'd0);
    add_random(40);

    wait_idle();
    cfg_write(REG_TICK_TIME, 32'($urandom_range(1, 300)));
    cfg_write(REG_DEFAULT_WORD, {8'h00, WORD_W'($urandom)});
    add_random(150);

    wait_idle();
    cfg_write(REG_TICK_TIME, 32'(TICK_TIME_RST));
    add_random(150);

    wait_idle();
    if (fail_count == 0) begin
      $display("burst_spacing_sample_sequencer test passed");
    end else begin
      $display("burst_spacing_sample_sequencer test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("burst_spacing_sample_sequencer test failed");
    $finish;
  end

  // Sender: presents queued items in bursts separated by random gaps.
  always @(posedge clk) begin : sender
    logic    present;
    sample_t smp;
    int      r;
    present = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (sequence_step(model_now, item_queue[0], smp)) expected_samples.push_back(smp);
        void'(item_queue.pop_front());
        present = 1'b0;
      end
      if (!present) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (item_queue.size() != 0) begin
          in_command      <= item_queue[0].command;
          in_entry_index  <= item_queue[0].entry_index;
          in_burst_time   <= item_queue[0].burst_time;
          in_spacing_time <= item_queue[0].spacing_time;
          in_repeat_total <= item_queue[0].repeat_total;
          in_burst_word   <= item_queue[0].burst_word;
          in_idle_word    <= item_queue[0].idle_word;
          in_entry_count  <= item_queue[0].entry_count;
          present = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            gap_left = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 30);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= present;
    end
  end

  // Receiver: switches between no stalls, random stalls and long stall runs.
  always @(posedge clk) begin : receiver
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(30, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:   stall_next = 1'b0;
      STALL_RANDOM: stall_next = ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          stall_next = ~stall_next;
          run_left   = $urandom_range(1, 16);
        end else begin
          run_left--;
        end
      end
    endcase
    out_stall <= stall_next;
  end

  // Monitor: every result transfer is matched against the oldest expected sample.
  always @(posedge clk) begin : monitor
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result transfer: sample_word %h", out_sample_word);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_word !== want.sample_word) begin
          $error("sample_word mismatch: expected %h, actual %h", want.sample_word,
                 out_sample_word);
          fail_count++;
        end
        if (out_phase !== want.phase) begin
          $error("phase mismatch: expected %b, actual %b", want.phase, out_phase);
          fail_count++;
        end
        if (out_list_wrapped !== want.list_wrapped) begin
          $error("list_wrapped mismatch: expected %b, actual %b", want.list_wrapped,
                 out_list_wrapped);
          fail_count++;
        end
      end
    end
  end

endmodule
